// ===== rtl/core/ptt_pkg.sv =====
package ptt_pkg;

   localparam int DEF_NUM_SLOTS = 8;
   localparam int CMD_DEPTH     = 2;
   localparam int RSP_DEPTH     = 4;

   localparam int TYPE_W = 2;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 3;
   localparam int MASK_W = 8;
   localparam int KIND_W = 3;
   localparam int REM_W  = 40;

   localparam logic [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

   typedef enum logic [TYPE_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRED   = 3'd0,
      KIND_DROPPED = 3'd1,
      KIND_DONE    = 3'd2,
      KIND_ADDED   = 3'd3,
      KIND_FULL    = 3'd4,
      KIND_REMOVED = 3'd5,
      KIND_EMPTY   = 3'd6
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_REMOVE,
      ST_VISIT,
      ST_SUB,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      req_kind_type      op;
      logic [TIME_W-1:0] delta;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] initial_delay;
      logic              keep_phase;
      logic              guarded;
      logic [MASK_W-1:0] cancel_mask;
   } cmd_type;

   typedef struct packed {
      rsp_kind_type      kind;
      logic [SLOT_W-1:0] slot_res;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/core/ptt_fifo.sv =====
module ptt_fifo #(
   parameter int DEPTH = ptt_pkg::CMD_DEPTH,
   parameter type data_type = ptt_pkg::cmd_type
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  data_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output data_type rd_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/ptt_front.sv =====
module ptt_front #(
   parameter int DEPTH = ptt_pkg::CMD_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [ptt_pkg::TYPE_W-1:0]      req_type,
   input  logic [ptt_pkg::TIME_W-1:0]      req_delta,
   input  logic [ptt_pkg::SLOT_W-1:0]      req_slot,
   input  logic [ptt_pkg::TIME_W-1:0]      req_period,
   input  logic [ptt_pkg::TIME_W-1:0]      req_initial_delay,
   input  logic                            req_keep_phase,
   input  logic                            req_guarded,
   input  logic [ptt_pkg::MASK_W-1:0]      req_cancel_mask,
   output logic                            cmd_valid,
   output ptt_pkg::cmd_type                cmd,
   input  logic                            cmd_pop
);

   ptt_pkg::cmd_type cmd_new;
   logic             enq;
   logic             q_empty;

   // unknown request codes are taken and discarded here
   always_comb begin
      cmd_new.op            = ptt_pkg::req_kind_type'(req_type);
      cmd_new.delta         = req_delta;
      cmd_new.slot          = req_slot;
      cmd_new.period        = req_period;
      cmd_new.initial_delay = req_initial_delay;
      cmd_new.keep_phase    = req_keep_phase;
      cmd_new.guarded       = req_guarded;
      cmd_new.cancel_mask   = req_cancel_mask;
   end

   assign enq       = push && !full && (cmd_new.op != ptt_pkg::REQ_NONE);
   assign cmd_valid = !q_empty;

   ptt_fifo #(
      .DEPTH     (DEPTH),
      .data_type (ptt_pkg::cmd_type)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (enq),
      .wr_data (cmd_new),
      .full    (full),
      .rd_en   (cmd_pop),
      .rd_data (cmd),
      .empty   (q_empty)
   );

endmodule

// ===== rtl/core/ptt_engine.sv =====
module ptt_engine #(
   parameter int NUM_SLOTS = ptt_pkg::DEF_NUM_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  ptt_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ptt_pkg::rsp_type rsp
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int REM_W = ptt_pkg::REM_W;
   localparam int TIME_W = ptt_pkg::TIME_W;

   ptt_pkg::state_type     state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [NUM_SLOTS-1:0]   used_ff, used_in;
   logic [NUM_SLOTS-1:0]   guard_ff, guard_in;
   logic [NUM_SLOTS-1:0]   keep_ff, keep_in;
   ptt_pkg::cmd_type       cmd_ff, cmd_in;
   logic [REM_W-1:0]       diff_ff, diff_in;

   logic [TIME_W-1:0]      period_mem [NUM_SLOTS];
   logic [REM_W-1:0]       rem_mem [NUM_SLOTS];
   logic [TIME_W-1:0]      period_rd_ff;
   logic [REM_W-1:0]       rem_rd_ff;

   logic                   rd_en;
   logic                   wr_rem_en, wr_period_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [REM_W-1:0]       wr_rem;

   logic [NUM_SLOTS-1:0]   mask_vec, rm_vec;
   logic                   rm_ok;
   logic [IDX_W-1:0]       free_idx;
   logic                   free_found;
   logic                   last_slot;
   logic [IDX_W-1:0]       next_idx;
   logic [REM_W:0]         sub_wide, add_wide;
   logic [REM_W-1:0]       sub_sat, reload;
   logic                   fire;

   // per-slot decode of the cancel mask, the remove target and the lowest free slot
   always_comb begin
      mask_vec   = '0;
      rm_vec     = '0;
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         mask_vec[i] = (i < 8) && cmd_ff.cancel_mask[i % 8];
         rm_vec[i]   = (i < 8) && (cmd_ff.slot == ptt_pkg::SLOT_W'(i % 8));
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx   = IDX_W'(i);
            free_found = 1'b1;
         end
      end
   end

   assign rm_ok     = |(rm_vec & used_ff);
   assign last_slot = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign next_idx  = idx_ff + IDX_W'(1);

   // remaining minus delta, clamped at the most negative value
   assign sub_wide = {rem_rd_ff[REM_W-1], rem_rd_ff} - {{(REM_W + 1 - TIME_W){1'b0}}, cmd_ff.delta};
   assign sub_sat  = (sub_wide[REM_W] && !sub_wide[REM_W-1]) ? ptt_pkg::REM_MIN
                                                              : sub_wide[REM_W-1:0];
   assign fire     = sub_sat[REM_W-1] || (sub_sat == '0);

   // diff is at most zero here, so adding a period never leaves the range
   assign add_wide = {diff_ff[REM_W-1], diff_ff} + {{(REM_W + 1 - TIME_W){1'b0}}, period_rd_ff};
   assign reload   = keep_ff[idx_ff] ? add_wide[REM_W-1:0]
                                     : {{(REM_W - TIME_W){1'b0}}, period_rd_ff};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      guard_in     = guard_ff;
      keep_in      = keep_ff;
      cmd_in       = cmd_ff;
      diff_in      = diff_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp.kind     = ptt_pkg::KIND_DONE;
      rsp.slot_res = '0;
      rsp.last     = 1'b0;
      rd_en        = 1'b0;
      wr_rem_en    = 1'b0;
      wr_period_en = 1'b0;
      wr_addr      = idx_ff;
      wr_rem       = reload;

      case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               idx_in  = '0;
               case (cmd.op)
                  ptt_pkg::REQ_TICK:   state_in = ptt_pkg::ST_VISIT;
                  ptt_pkg::REQ_ADD:    state_in = ptt_pkg::ST_ADD;
                  ptt_pkg::REQ_REMOVE: state_in = ptt_pkg::ST_REMOVE;
                  default:             state_in = ptt_pkg::ST_IDLE;
               endcase
            end
         end

         ptt_pkg::ST_ADD: begin
            rsp.last = 1'b1;
            if (free_found) begin
               rsp.kind     = ptt_pkg::KIND_ADDED;
               rsp.slot_res = ptt_pkg::SLOT_W'(free_idx);
            end else begin
               rsp.kind     = ptt_pkg::KIND_FULL;
               rsp.slot_res = '0;
            end
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ptt_pkg::ST_IDLE;
               if (free_found) begin
                  used_in[free_idx]  = 1'b1;
                  guard_in[free_idx] = cmd_ff.guarded;
                  keep_in[free_idx]  = cmd_ff.keep_phase;
                  wr_addr            = free_idx;
                  wr_rem             = {{(REM_W - TIME_W){1'b0}}, cmd_ff.initial_delay};
                  wr_rem_en          = 1'b1;
                  wr_period_en       = 1'b1;
               end
            end
         end

         ptt_pkg::ST_REMOVE: begin
            rsp.last     = 1'b1;
            rsp.slot_res = cmd_ff.slot;
            rsp.kind     = rm_ok ? ptt_pkg::KIND_REMOVED : ptt_pkg::KIND_EMPTY;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ptt_pkg::ST_IDLE;
               if (rm_ok) begin
                  used_in = used_ff & ~rm_vec;
               end
            end
         end

         ptt_pkg::ST_VISIT: begin
            rsp.kind     = ptt_pkg::KIND_DROPPED;
            rsp.slot_res = ptt_pkg::SLOT_W'(idx_ff);
            if (!used_ff[idx_ff]) begin
               idx_in   = next_idx;
               state_in = last_slot ? ptt_pkg::ST_DONE : ptt_pkg::ST_VISIT;
            end else if (guard_ff[idx_ff] && mask_vec[idx_ff]) begin
               if (!rsp_full) begin
                  rsp_push        = 1'b1;
                  used_in[idx_ff] = 1'b0;
                  idx_in          = next_idx;
                  state_in        = last_slot ? ptt_pkg::ST_DONE : ptt_pkg::ST_VISIT;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = ptt_pkg::ST_SUB;
            end
         end

         ptt_pkg::ST_SUB: begin
            diff_in = sub_sat;
            if (fire) begin
               state_in = ptt_pkg::ST_UPD;
            end else begin
               wr_rem    = sub_sat;
               wr_rem_en = 1'b1;
               idx_in    = next_idx;
               state_in  = last_slot ? ptt_pkg::ST_DONE : ptt_pkg::ST_VISIT;
            end
         end

         ptt_pkg::ST_UPD: begin
            rsp.kind     = ptt_pkg::KIND_FIRED;
            rsp.slot_res = ptt_pkg::SLOT_W'(idx_ff);
            if (!rsp_full) begin
               rsp_push  = 1'b1;
               wr_rem_en = 1'b1;
               idx_in    = next_idx;
               state_in  = last_slot ? ptt_pkg::ST_DONE : ptt_pkg::ST_VISIT;
            end
         end

         ptt_pkg::ST_DONE: begin
            rsp.kind     = ptt_pkg::KIND_DONE;
            rsp.slot_res = '0;
            rsp.last     = 1'b1;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ptt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ptt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
         idx_ff   <= '0;
         used_ff  <= '0;
         guard_ff <= '0;
         keep_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         used_ff  <= used_in;
         guard_ff <= guard_in;
         keep_ff  <= keep_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      diff_ff <= diff_in;
   end

   always_ff @(posedge clock) begin
      if (wr_rem_en) begin
         rem_mem[wr_addr] <= wr_rem;
      end
      if (wr_period_en) begin
         period_mem[wr_addr] <= cmd_ff.period;
      end
      if (rd_en) begin
         rem_rd_ff    <= rem_mem[idx_ff];
         period_rd_ff <= period_mem[idx_ff];
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result written into a full queue");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ptt_pkg::ST_IDLE))
      else $error("command taken while busy");

   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.last) |=> (state_ff == ptt_pkg::ST_IDLE))
      else $error("final beat did not end the request");

   a_add_takes_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptt_pkg::ST_ADD && rsp_push && free_found) |=> used_ff[$past(free_idx)])
      else $error("added slot not marked in use");

   a_fire_from_sub: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptt_pkg::ST_UPD) |-> ($past(state_ff) == ptt_pkg::ST_SUB
                                         || $past(state_ff) == ptt_pkg::ST_UPD))
      else $error("fire step entered without a subtract step");

endmodule

// ===== rtl/core/periodic_task_timer_table.sv =====
// an add or a remove gives its single beat via the queue, the dispatch and the reply state
// a tick passes the queue and the dispatch, then per slot: the visit step only if unused or
// dropped, visit and subtract if it counts down without firing, visit, subtract and update if
// it fires; then the done beat. One request at a time in the back end, which a full queue stalls
// reset: synchronous, clears the queues, the sequencer and the used/guarded/keep-phase bits;
// the period and remaining-time memories are not cleared and are always written by an add first
module periodic_task_timer_table #(
   parameter int NUM_SLOTS = ptt_pkg::DEF_NUM_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request side
   input  logic                       push,
   output logic                       full,
   input  logic [ptt_pkg::TYPE_W-1:0] req_type,
   input  logic [ptt_pkg::TIME_W-1:0] req_delta,
   input  logic [ptt_pkg::SLOT_W-1:0] req_slot,
   input  logic [ptt_pkg::TIME_W-1:0] req_period,
   input  logic [ptt_pkg::TIME_W-1:0] req_initial_delay,
   input  logic                       req_keep_phase,
   input  logic                       req_guarded,
   input  logic [ptt_pkg::MASK_W-1:0] req_cancel_mask,
   // result side
   output logic                       empty,
   input  logic                       pop,
   output logic [ptt_pkg::KIND_W-1:0] rsp_kind,
   output logic [ptt_pkg::SLOT_W-1:0] rsp_slot_res,
   output logic                       rsp_last
);

   // front to back command queue
   logic             cmd_valid;
   logic             cmd_pop;
   ptt_pkg::cmd_type cmd;

   // back end result beats into the output queue
   logic             rsp_push;
   logic             rsp_full;
   ptt_pkg::rsp_type rsp_wr;
   ptt_pkg::rsp_type rsp_head;

   // front: takes a beat while not full, drops unknown codes, buffers the rest
   ptt_front #(
      .DEPTH (ptt_pkg::CMD_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_delta         (req_delta),
      .req_slot          (req_slot),
      .req_period        (req_period),
      .req_initial_delay (req_initial_delay),
      .req_keep_phase    (req_keep_phase),
      .req_guarded       (req_guarded),
      .req_cancel_mask   (req_cancel_mask),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   // back: slot table and the tick walk over it
   ptt_engine #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // result queue, head beat drives the ports
   ptt_fifo #(
      .DEPTH     (ptt_pkg::RSP_DEPTH),
      .data_type (ptt_pkg::rsp_type)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_head),
      .empty   (empty)
   );

   assign rsp_kind     = rsp_head.kind;
   assign rsp_slot_res = rsp_head.slot_res;
   assign rsp_last     = rsp_head.last;

endmodule
